// ----- rtl/ssms_pkg.sv -----
package ssms_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Series length limits
    localparam int MAX_SERIES  = 1048576;
    localparam int IDX_W       = $clog2(MAX_SERIES);
    localparam int POS_W       = $clog2(MAX_SERIES + 1);

    // Field widths
    localparam int PRICE_W     = 32;
    localparam int SPAN_W      = 21;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 24;

    // One stack entry: position of the sample and its price
    typedef struct packed {
        logic [IDX_W-1:0]          pos;
        logic signed [PRICE_W-1:0] price;
    } entry_t;

endpackage

// ----- rtl/stock_span_monotonic_stack.sv -----
// Stock span unit built around a monotonic stack held in a single-port-write,
// registered-read memory.
//
// Input channel (s_*): one price sample per transfer. s_tdata carries the
// signed Q16.16 price, s_tuser is set on the first sample of a series, which
// empties the stack and restarts the position count before the sample is used.
// Result channel (m_*): one transfer per sample. m_tdata carries the span,
// m_tuser the sticky overflow flag (stack full or series too long).
//
// Timing: a sample is accepted in the idle state, then each pop step removes
// one entry and reads the one below it through the registered read port.
// Every sample pushes one entry and every entry is popped at most once, so
// a long series pops no more entries than it has samples. The result is
// loaded into the output register at the last scan step, which raises
// m_tvalid. The next sample is taken while a result still waits in the
// output register; the scan only stalls at its last step when that register
// is still full and m_tready is low.
//
// Reset (aresetn low, synchronous) empties the stack, clears the position and
// the overflow flag and drops m_tvalid. The memory contents are not cleared.
module stock_span_monotonic_stack (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ssms_pkg::IN_DATA_W-1:0]    s_tdata,   // [31:0] price
    input  logic                              s_tuser,   // [0] first_of_series
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ssms_pkg::OUT_DATA_W-1:0]   m_tdata,   // [20:0] span, upper bits zero
    output logic                              m_tuser    // [0] overflow
);
    import ssms_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(STACK_DEPTH);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_SERIES);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(MAX_SERIES - 1);

    // Control and working registers
    logic                      state_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [POS_W-1:0]          position_reg;
    logic                      error_reg;
    logic signed [PRICE_W-1:0] price_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic                      use_mem_reg;
    entry_t                    top_reg;

    // Output register
    logic              out_valid_reg;
    logic [SPAN_W-1:0] span_reg;
    logic              ovf_reg;

    // Stack memory
    entry_t stack_mem [STACK_DEPTH];
    entry_t rd_data_reg;

    logic              accept;
    logic              out_free;
    entry_t            cand;
    logic              pop;
    logic              finish;
    logic [POS_W-1:0]  pos_start;
    logic              pos_sat;
    logic [SPAN_W-1:0] span_next;
    logic [CNT_W-1:0]  rd_cnt;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              stack_full;
    logic [SPAN_W-1:0] span_diff;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Position of the incoming sample, saturating at the series limit.
    assign pos_start = s_tuser ? '0 : position_reg;
    assign pos_sat   = (pos_start >= POS_LIMIT);

    // The entry under comparison: cached top first, then entries read back.
    assign cand   = use_mem_reg ? rd_data_reg : top_reg;
    assign pop    = (state_reg == ST_SCAN) && (count_reg != '0) &&
                    (cand.price <= price_reg);
    assign finish = (state_reg == ST_SCAN) && !pop && out_free;

    // Read the entry that becomes the top after this pop.
    assign rd_cnt  = count_reg - CNT_W'(2);
    assign rd_addr = rd_cnt[ADDR_W-1:0];

    // A full stack overwrites its top entry.
    assign stack_full = (count_reg >= CNT_FULL);
    assign wr_addr    = stack_full ? ADDR_W'(STACK_DEPTH - 1) : count_reg[ADDR_W-1:0];

    // Span: distance to the nearest higher price, never below one.
    always_comb begin
        span_diff = SPAN_W'(idx_reg) - SPAN_W'(cand.pos);
        if (count_reg == '0) begin
            span_next = SPAN_W'(idx_reg) + SPAN_W'(1);
        end else if (cand.pos < idx_reg) begin
            span_next = span_diff;
        end else begin
            span_next = SPAN_W'(1);
        end
    end

    // Memory: one write port for pushes, one registered read port for pops.
    always_ff @(posedge aclk) begin
        if (finish) begin
            stack_mem[wr_addr] <= '{pos: idx_reg, price: price_reg};
        end
        if (pop && (count_reg >= CNT_W'(2))) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            price_reg <= $signed(s_tdata[PRICE_W-1:0]);
            idx_reg   <= pos_sat ? IDX_LAST : pos_start[IDX_W-1:0];
        end
        if (finish) begin
            top_reg  <= '{pos: idx_reg, price: price_reg};
            span_reg <= span_next;
        end
    end

    // Control: sample intake, pop scan, push and result hand-off.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            position_reg  <= '0;
            error_reg     <= 1'b0;
            use_mem_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg    <= ST_SCAN;
                        use_mem_reg  <= 1'b0;
                        position_reg <= pos_sat ? POS_LIMIT : pos_start + POS_W'(1);
                        if (s_tuser) begin
                            count_reg <= '0;
                        end
                        if (pos_sat) begin
                            error_reg <= 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    if (pop) begin
                        count_reg   <= count_reg - CNT_W'(1);
                        use_mem_reg <= 1'b1;
                    end else if (finish) begin
                        state_reg <= ST_IDLE;
                        ovf_reg   <= error_reg || stack_full;
                        if (stack_full) begin
                            error_reg <= 1'b1;
                            count_reg <= CNT_FULL;
                        end else begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // The result register fills at the last scan step and empties on transfer.
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(span_reg);
    assign m_tuser  = ovf_reg;

endmodule

// ----- tb/span_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the span unit, predicts the span and the sticky
// overflow flag of every accepted sample and compares them with the results.
module span_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ssms_pkg::IN_DATA_W-1:0]  s_tdata,    // [31:0] price
    input  logic                            s_tuser,    // [0] first_of_series
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ssms_pkg::OUT_DATA_W-1:0] m_tdata,    // [20:0] span, upper bits zero
    input  logic                            m_tuser,    // [0] overflow
    output int                              fail_count,
    output int                              spans_pending
);
    import ssms_pkg::*;

    localparam int SPAN_MAX = (MAX_SERIES < (1 << SPAN_W)) ? MAX_SERIES : (1 << SPAN_W) - 1;

    typedef struct packed {
        logic [SPAN_W-1:0] span;
        logic              overflow;
    } span_result_t;

    span_result_t expected_spans[$];

    // Private copy of the monotonic stack and the series state.
    logic signed [PRICE_W-1:0] stk_price [STACK_DEPTH];
    int                        stk_pos   [STACK_DEPTH];
    int                        depth      = 0;
    int                        series_pos = 0;
    logic                      sticky_err = 1'b0;
    int                        errors     = 0;

    // Works out the span of one sample and queues it with the overflow flag.
    task automatic predict_span(input logic signed [PRICE_W-1:0] price, input logic first);
        int           idx;
        int           span;
        span_result_t res;
        if (first) begin
            depth      = 0;
            series_pos = 0;
        end
        // An over-long series is handled at the last valid position.
        if (series_pos >= MAX_SERIES) begin
            sticky_err = 1'b1;
            idx        = MAX_SERIES - 1;
        end else begin
            idx = series_pos;
        end
        // Pop every entry whose price does not exceed the new one.
        while (depth > 0 && depth <= STACK_DEPTH && stk_price[depth-1] <= price)
            depth--;
        if (depth == 0)
            span = idx + 1;
        else if (stk_pos[depth-1] <= idx)
            span = idx - stk_pos[depth-1];
        else
            span = 0;
        if (span < 1)
            span = 1;
        if (span > SPAN_MAX)
            span = SPAN_MAX;
        // A full stack keeps its size and the new sample replaces the top entry.
        if (depth >= STACK_DEPTH) begin
            sticky_err              = 1'b1;
            depth                   = STACK_DEPTH;
            stk_price[STACK_DEPTH-1] = price;
            stk_pos[STACK_DEPTH-1]   = idx;
        end else begin
            stk_price[depth] = price;
            stk_pos[depth]   = idx;
            depth++;
        end
        if (idx + 1 > series_pos)
            series_pos = idx + 1;
        if (series_pos > MAX_SERIES)
            series_pos = MAX_SERIES;
        res.span     = span[SPAN_W-1:0];
        res.overflow = sticky_err;
        expected_spans.push_back(res);
    endtask

    // Predict on each input transfer, compare on each result transfer.
    always @(posedge aclk) begin
        span_result_t want;
        if (!aresetn) begin
            depth      = 0;
            series_pos = 0;
            sticky_err = 1'b0;
            expected_spans.delete();
        end else begin
            if (s_tvalid && s_tready)
                predict_span($signed(s_tdata[PRICE_W-1:0]), s_tuser);
            if (m_tvalid && m_tready) begin
                if (expected_spans.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, got span %0d overflow %0b",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = expected_spans.pop_front();
                    if (m_tdata !== {{(OUT_DATA_W-SPAN_W){1'b0}}, want.span}) begin
                        errors++;
                        $display("%0t: span mismatch: expected %0d, got %0d",
                                 $time, want.span, m_tdata);
                    end
                    if (m_tuser !== want.overflow) begin
                        errors++;
                        $display("%0t: overflow mismatch: expected %0b, got %0b",
                                 $time, want.overflow, m_tuser);
                    end
                end
            end
        end
        fail_count    <= errors;
        spans_pending <= expected_spans.size();
    end

endmodule

// ----- tb/tb_stock_span_monotonic_stack.sv -----
`timescale 1ns / 100ps

module tb_stock_span_monotonic_stack;
    import ssms_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int LONG_HOLD      = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 64;
    localparam int PHASE_ITEMS    = 40;
    localparam int NUM_DIRECTED   = 23;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tready = 1'b0;
    logic                  hold_req = 1'b0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire [OUT_DATA_W-1:0]  m_tdata;
    wire                   m_tuser;

    int fail_count;
    int spans_pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int samples_sent   = 0;
    int quiet_cycles   = 0;

    // Directed samples: extremes of the price, equal prices, sign boundaries,
    // series restarts and a sawtooth with pops of several entries.
    logic [PRICE_W-1:0] dir_px [NUM_DIRECTED] = '{
        32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
        32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
        32'h0005_0000, 32'h0004_0000, 32'h0003_0000, 32'h0006_0000, 32'h0002_0000,
        32'h0002_0000, 32'h0007_0000, 32'h0001_0000, 32'h0008_0000, 32'hFFFF_8000,
        32'hFFFF_8000, 32'hFFFF_7FFF, 32'h7FFF_FFFF
    };
    logic dir_first [NUM_DIRECTED] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0
    };

    stock_span_monotonic_stack u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    span_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .spans_pending (spans_pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Result side: random stalls, or a long hold-off when requested.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req)
                hold_left = LONG_HOLD;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one sample after a random gap and waits for its transfer.
    task automatic send_sample(input logic [PRICE_W-1:0] price, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= price;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // Stops offering and waits until every predicted span has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (spans_pending != 0);
    endtask

    // One series of random length, at most max_len, in one of several price
    // patterns. Most series start with the first-of-series flag; a few stray
    // flags are noise.
    task automatic send_random_series(input int max_len);
        int                 len;
        int                 style;
        int                 k;
        logic [PRICE_W-1:0] px;
        logic               flag;
        len   = ($urandom_range(19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        if (len > max_len)
            len = max_len;
        style = $urandom_range(3);
        px    = $urandom;
        for (k = 0; k < len; k++) begin
            case (style)
                0: px = px + $urandom_range(64) - 32;
                1: px = $urandom;
                2: px = ($urandom_range(4) << 16) - 32'h0002_0000;
                default: begin
                    if (k < len / 2)
                        px = px - $urandom_range(1, 1000);
                    else
                        px = px + $urandom_range(1500);
                end
            endcase
            flag = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
            send_sample(px, flag);
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int target;
        send_idle_pct   = idle_pct;
        recv_stall_pct <= stall_pct;
        target = samples_sent + PHASE_ITEMS;
        while (samples_sent < target)
            send_random_series(target - samples_sent);
        wait_drained();
    endtask

    initial begin
        int                 k;
        logic [PRICE_W-1:0] px;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed samples with no idling.
        for (k = 0; k < NUM_DIRECTED; k++)
            send_sample(dir_px[k], dir_first[k]);
        wait_drained();

        // Back-pressure: the result side holds off while samples keep coming.
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        for (k = 0; k < 24; k++)
            send_sample($urandom, 1'($urandom_range(1)));
        wait_drained();

        // Random phases over the idling patterns.
        run_random_phase(0, 0);
        run_random_phase(62, 0);
        run_random_phase(0, 62);
        run_random_phase(38, 38);

        // Stack full: a strictly falling series deeper than the stack, then
        // samples that pop into the overwritten top and one that empties it.
        send_idle_pct   = 38;
        recv_stall_pct <= 38;
        px = 32'h7FFF_FFFF;
        send_sample(px, 1'b1);
        for (k = 0; k < STACK_DEPTH + 4; k++) begin
            px = px - $urandom_range(1, 3);
            send_sample(px, 1'b0);
        end
        for (k = 0; k < 12; k++)
            send_sample(px + $urandom_range(200) - 60, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_random_series(20);
        wait_drained();

        // Let any late result show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && spans_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
